// ===== design/calibrated_resistance_trimmed_mean_assert.svh =====
// Assertion macros for the calibrated resistance back end.
`ifndef CALIBRATED_RESISTANCE_TRIMMED_MEAN_ASSERT_SVH
`define CALIBRATED_RESISTANCE_TRIMMED_MEAN_ASSERT_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define CRTM_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("crtm: same-cycle check failed");

// Next-cycle implication, sampled on clock and disabled during reset.
`define CRTM_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("crtm: next-cycle check failed");

`endif

// ===== design/crtm_pkg.sv =====
// Package with widths, constants and shared types of the calibrated resistance block.
package crtm_pkg;

   // Group and calibration constants.
   localparam int GROUP_SIZE = 5;
   localparam int TRIM_DIV   = GROUP_SIZE - 2;
   localparam int OHM_SPAN   = 900;
   localparam int OHM_BASE   = 100;
   localparam int OHM_MAX    = 65535;

   // Widths.
   localparam int CODE_W    = 16;
   localparam int SPAN_W    = $clog2(OHM_SPAN + 1);
   localparam int NUM_W     = CODE_W + SPAN_W;
   localparam int SUM_W     = 20;
   localparam int CNT_W     = $clog2(GROUP_SIZE);
   localparam int DIV_CNT_W = $clog2(NUM_W);
   localparam int CSR_IDX_W = 8;

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_LOW_REF  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_REF = CSR_IDX_W'(1);

   // One classified sample, as handed from front to back.
   typedef struct packed {
      logic [NUM_W-1:0]  num_mag;
      logic              neg;
      logic [CODE_W-1:0] den_mag;
      logic              zero_span;
   } cal_item_type;

   // Request to the shared divider.
   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  dividend;
      logic [CODE_W-1:0] divisor;
   } div_req_type;

   // Status and result of the shared divider.
   typedef struct packed {
      logic             busy;
      logic             done;
      logic [NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== design/crtm_if.sv =====
// Channel interfaces: sample requests, results and register writes.
interface crtm_req_if;
   logic                       valid;
   logic                       ready;
   logic [crtm_pkg::CODE_W-1:0] adc_code;

   modport source (output valid, output adc_code, input ready);
   modport sink (input valid, input adc_code, output ready);
endinterface

interface crtm_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [crtm_pkg::CODE_W-1:0] sample_ohms;
   logic                       range_flag;
   logic                       group_done;
   logic [crtm_pkg::CODE_W-1:0] trimmed_ohms;

   modport source (output valid, output sample_ohms, output range_flag,
                   output group_done, output trimmed_ohms, input ready);
   modport sink (input valid, input sample_ohms, input range_flag,
                 input group_done, input trimmed_ohms, output ready);
endinterface

interface crtm_csr_if;
   logic                          valid;
   logic                          ready;
   logic [crtm_pkg::CSR_IDX_W-1:0] reg_index;
   logic [crtm_pkg::CODE_W-1:0]    wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== design/crtm_queue.sv =====
// Short register queue that decouples the front from the back.
module crtm_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  crtm_pkg::cal_item_type push_item,
   output logic                   full,
   input  logic                   pop,
   output logic                   avail,
   output crtm_pkg::cal_item_type pop_item
);

   crtm_pkg::cal_item_type         entry_ff [crtm_pkg::QUEUE_DEPTH];
   logic [crtm_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [crtm_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [crtm_pkg::QPTR_W:0]      count_ff, count_in;
   logic                           push_ok;
   logic                           pop_ok;

   // Status toward both sides.
   assign full     = (count_ff == (crtm_pkg::QPTR_W+1)'(crtm_pkg::QUEUE_DEPTH));
   assign avail    = (count_ff != '0);
   assign pop_item = entry_ff[rd_ptr_ff];
   assign push_ok  = push && !full;
   assign pop_ok   = pop && avail;

   // Pointer and fill count updates with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == crtm_pkg::QPTR_W'(crtm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == crtm_pkg::QPTR_W'(crtm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + (crtm_pkg::QPTR_W+1)'(push_ok) - (crtm_pkg::QPTR_W+1)'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/crtm_front.sv =====
// Front end: accepts ADC codes, forms the scaled numerator and span, and queues them.
module crtm_front (
   input  logic                       clock,
   input  logic                       reset,
   crtm_req_if.sink                   req_ch,
   input  logic [crtm_pkg::CODE_W-1:0] low_ref,
   input  logic [crtm_pkg::CODE_W-1:0] high_ref,
   input  logic                       q_full,
   output logic                       q_push,
   output crtm_pkg::cal_item_type     q_item
);

   logic                       valid_ff, valid_in;
   crtm_pkg::cal_item_type     item_ff, item_in;
   logic                       accept;
   logic [crtm_pkg::CODE_W:0]  diff;
   logic [crtm_pkg::CODE_W:0]  diff_abs;
   logic [crtm_pkg::CODE_W:0]  den;
   logic [crtm_pkg::CODE_W:0]  den_abs;

   // One holding stage; it frees up as soon as the queue takes its sample.
   assign q_push       = valid_ff && !q_full;
   assign req_ch.ready = !valid_ff || !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign q_item       = item_ff;

   // Signed distance from the low reference and signed calibration span, as magnitudes.
   always_comb begin
      diff     = {1'b0, req_ch.adc_code} - {1'b0, low_ref};
      diff_abs = diff[crtm_pkg::CODE_W] ? (~diff + 1'b1) : diff;
      den      = {1'b0, high_ref} - {1'b0, low_ref};
      den_abs  = den[crtm_pkg::CODE_W] ? (~den + 1'b1) : den;

      item_in.num_mag   = crtm_pkg::NUM_W'(diff_abs[crtm_pkg::CODE_W-1:0])
                        * crtm_pkg::NUM_W'(crtm_pkg::OHM_SPAN);
      item_in.neg       = diff[crtm_pkg::CODE_W] ^ den[crtm_pkg::CODE_W];
      item_in.den_mag   = den_abs[crtm_pkg::CODE_W-1:0];
      item_in.zero_span = (high_ref == low_ref);
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== design/crtm_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module crtm_div (
   input  logic                  clock,
   input  logic                  reset,
   input  crtm_pkg::div_req_type div_req,
   output crtm_pkg::div_rsp_type div_rsp
);

   logic                           busy_ff;
   logic                           done_ff;
   logic [crtm_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [crtm_pkg::CODE_W-1:0]    rem_ff;
   logic [crtm_pkg::NUM_W-1:0]     quo_ff;
   logic [crtm_pkg::CODE_W-1:0]    divisor_ff;
   logic [crtm_pkg::CODE_W:0]      trial;
   logic                           fits;

   // Shift in the next dividend bit and test it against the divisor.
   assign trial = {rem_ff, quo_ff[crtm_pkg::NUM_W-1]};
   assign fits  = (trial >= {1'b0, divisor_ff});

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == crtm_pkg::DIV_CNT_W'(crtm_pkg::NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: the quotient register starts as the dividend and fills from the right.
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quo_ff     <= div_req.dividend;
         rem_ff     <= '0;
         divisor_ff <= div_req.divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[crtm_pkg::NUM_W-2:0], fits};
         rem_ff <= fits ? crtm_pkg::CODE_W'(trial - {1'b0, divisor_ff})
                        : trial[crtm_pkg::CODE_W-1:0];
      end
   end

endmodule

// ===== design/crtm_back.sv =====
// Back end: divides, clamps, keeps group statistics and presents the result.
module crtm_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_avail,
   input  crtm_pkg::cal_item_type q_item,
   output logic                   q_pop,
   output crtm_pkg::div_req_type  div_req,
   input  crtm_pkg::div_rsp_type  div_rsp,
   crtm_rsp_if.source             rsp_ch
);

`include "calibrated_resistance_trimmed_mean_assert.svh"

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_CLAMP,
      ST_ACCUM,
      ST_TRIM,
      ST_OUT
   } state_type;

   state_type                    state_ff;
   logic                         neg_ff;
   logic [crtm_pkg::CODE_W-1:0]  ohms_ff;
   logic                         flag_ff;
   logic                         done_ff;
   logic [crtm_pkg::CODE_W-1:0]  trimmed_ff;
   logic [crtm_pkg::CNT_W-1:0]   cnt_ff;
   logic [crtm_pkg::SUM_W-1:0]   sum_ff;
   logic [crtm_pkg::CODE_W-1:0]  min_ff;
   logic [crtm_pkg::CODE_W-1:0]  max_ff;

   logic [crtm_pkg::NUM_W:0]     pos_val;
   logic                         below;
   logic                         above;
   logic [crtm_pkg::SUM_W-1:0]   sum_new;
   logic [crtm_pkg::CODE_W-1:0]  min_new;
   logic [crtm_pkg::CODE_W-1:0]  max_new;
   logic [crtm_pkg::CODE_W:0]    ends;
   logic [crtm_pkg::SUM_W-1:0]   rest;
   logic                         last;
   logic                         trim_big;

   // Pop the next sample whenever the back is free.
   assign q_pop = (state_ff == ST_IDLE) && q_avail;

   // Divider requests: a sample quotient on a pop with nonzero span, the trimmed mean at a group end.
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = q_item.num_mag;
      div_req.divisor  = q_item.den_mag;
      if (q_pop && !q_item.zero_span) begin
         div_req.start = 1'b1;
      end else if ((state_ff == ST_ACCUM) && last) begin
         div_req.start    = 1'b1;
         div_req.dividend = crtm_pkg::NUM_W'(rest);
         div_req.divisor  = crtm_pkg::CODE_W'(crtm_pkg::TRIM_DIV);
      end
   end

   // Offset and range check of the truncated quotient.
   always_comb begin
      pos_val = (crtm_pkg::NUM_W+1)'(div_rsp.quotient)
              + (crtm_pkg::NUM_W+1)'(crtm_pkg::OHM_BASE);
      below   = neg_ff && (div_rsp.quotient > crtm_pkg::NUM_W'(crtm_pkg::OHM_BASE));
      above   = !neg_ff && (pos_val > (crtm_pkg::NUM_W+1)'(crtm_pkg::OHM_MAX));
   end

   // Group statistics including the current sample.
   always_comb begin
      sum_new  = sum_ff + crtm_pkg::SUM_W'(ohms_ff);
      min_new  = (ohms_ff < min_ff) ? ohms_ff : min_ff;
      max_new  = (ohms_ff > max_ff) ? ohms_ff : max_ff;
      ends     = {1'b0, min_new} + {1'b0, max_new};
      rest     = (sum_new >= crtm_pkg::SUM_W'(ends)) ? sum_new - crtm_pkg::SUM_W'(ends) : '0;
      last     = ({1'b0, cnt_ff} + 1'b1) >= (crtm_pkg::CNT_W+1)'(crtm_pkg::GROUP_SIZE);
      trim_big = (div_rsp.quotient[crtm_pkg::NUM_W-1:crtm_pkg::CODE_W] != '0);
   end

   // Sequencer with its registered outputs and group state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         min_ff   <= crtm_pkg::CODE_W'(crtm_pkg::OHM_MAX);
         max_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  neg_ff <= q_item.neg;
                  if (q_item.zero_span) begin
                     ohms_ff  <= crtm_pkg::CODE_W'(crtm_pkg::OHM_MAX);
                     flag_ff  <= 1'b1;
                     state_ff <= ST_ACCUM;
                  end else begin
                     state_ff <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               if (div_rsp.done) begin
                  state_ff <= ST_CLAMP;
               end
            end
            ST_CLAMP: begin
               flag_ff <= below || above;
               if (below) begin
                  ohms_ff <= '0;
               end else if (above) begin
                  ohms_ff <= crtm_pkg::CODE_W'(crtm_pkg::OHM_MAX);
               end else if (neg_ff) begin
                  ohms_ff <= crtm_pkg::CODE_W'(crtm_pkg::OHM_BASE)
                           - div_rsp.quotient[crtm_pkg::CODE_W-1:0];
               end else begin
                  ohms_ff <= pos_val[crtm_pkg::CODE_W-1:0];
               end
               state_ff <= ST_ACCUM;
            end
            ST_ACCUM: begin
               done_ff <= last;
               if (last) begin
                  cnt_ff   <= '0;
                  sum_ff   <= '0;
                  min_ff   <= crtm_pkg::CODE_W'(crtm_pkg::OHM_MAX);
                  max_ff   <= '0;
                  state_ff <= ST_TRIM;
               end else begin
                  cnt_ff     <= cnt_ff + 1'b1;
                  sum_ff     <= sum_new;
                  min_ff     <= min_new;
                  max_ff     <= max_new;
                  trimmed_ff <= '0;
                  state_ff   <= ST_OUT;
               end
            end
            ST_TRIM: begin
               if (div_rsp.done) begin
                  trimmed_ff <= trim_big ? crtm_pkg::CODE_W'(crtm_pkg::OHM_MAX)
                                         : div_rsp.quotient[crtm_pkg::CODE_W-1:0];
                  state_ff   <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_ch.ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid        = (state_ff == ST_OUT);
   assign rsp_ch.sample_ohms  = ohms_ff;
   assign rsp_ch.range_flag   = flag_ff;
   assign rsp_ch.group_done   = done_ff;
   assign rsp_ch.trimmed_ohms = trimmed_ff;

   // A result outside a group end carries no trimmed mean.
   `CRTM_ASSERT_IMPL(a_trim_zero, rsp_ch.valid && !rsp_ch.group_done, rsp_ch.trimmed_ohms == '0)
   // The shared divider is never restarted while it is still working.
   `CRTM_ASSERT_IMPL(a_div_free, div_req.start, !div_rsp.busy)
   // The sample count never reaches the group size.
   `CRTM_ASSERT_IMPL(a_cnt_range, 1'b1,
      {1'b0, cnt_ff} < (crtm_pkg::CNT_W+1)'(crtm_pkg::GROUP_SIZE))
   // A finished divide in the sample phase always leads to the clamp step.
   `CRTM_ASSERT_NEXT(a_div_clamp, (state_ff == ST_DIV) && div_rsp.done, state_ff == ST_CLAMP)

endmodule

// ===== design/calibrated_resistance_trimmed_mean.sv =====
// Top level of the calibrated resistance block with group trimmed mean.
//
// Use: ADC codes enter on req_ch, one result per code leaves on rsp_ch, and the
// two calibration codes are written over csr_ch (index 0 is the low reference,
// index 1 the high reference; other indexes are ignored). csr_ch is always ready
// and must be written only while no sample is in flight.
// Each result carries the clamped ohm value and its range flag; on the last
// sample of a group it also carries the trimmed mean with group_done set.
// A normal sample passes through the serial divider once; the sample that closes a
// group passes through the same one-bit-per-cycle divider again for the trimmed mean.
// The back takes its next sample only once the result of the last one has been taken,
// so the serial divider sets the sustained throughput.
// A front stage and a two-entry queue keep accepting codes while the back works
// or while a result waits, so up to three codes can be buffered ahead.
// When the receiver stalls, the result stays on rsp_ch unchanged and the back
// waits; the front then stops accepting once its holding stage and the queue are full.
// Reset is synchronous: it clears the group statistics, the queue, and sets the
// calibration to low 0 and high 65535.
module calibrated_resistance_trimmed_mean (
   input  logic      clock,
   input  logic      reset,
   crtm_req_if.sink  req_ch,
   crtm_rsp_if.source rsp_ch,
   crtm_csr_if.sink  csr_ch
);

   logic [crtm_pkg::CODE_W-1:0] low_ref_ff;
   logic [crtm_pkg::CODE_W-1:0] high_ref_ff;
   logic                        q_full;
   logic                        q_push;
   logic                        q_pop;
   logic                        q_avail;
   crtm_pkg::cal_item_type      push_item;
   crtm_pkg::cal_item_type      pop_item;
   crtm_pkg::div_req_type       div_req;
   crtm_pkg::div_rsp_type       div_rsp;

   // Calibration registers.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ref_ff  <= '0;
         high_ref_ff <= crtm_pkg::CODE_W'(crtm_pkg::OHM_MAX);
      end else if (csr_ch.valid) begin
         if (csr_ch.reg_index == crtm_pkg::REG_LOW_REF) begin
            low_ref_ff <= csr_ch.wr_data;
         end else if (csr_ch.reg_index == crtm_pkg::REG_HIGH_REF) begin
            high_ref_ff <= csr_ch.wr_data;
         end
      end
   end

   crtm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .low_ref  (low_ref_ff),
      .high_ref (high_ref_ff),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_item   (push_item)
   );

   crtm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .avail     (q_avail),
      .pop_item  (pop_item)
   );

   crtm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   crtm_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_avail (q_avail),
      .q_item  (pop_item),
      .q_pop   (q_pop),
      .div_req (div_req),
      .div_rsp (div_rsp),
      .rsp_ch  (rsp_ch)
   );

endmodule

// ===== test/calibrated_resistance_trimmed_mean_checker.sv =====
// Checker that predicts every calibrated reading and compares it with the block's results.
`timescale 1ns / 100ps

module calibrated_resistance_trimmed_mean_checker
   import crtm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   crtm_req_if  req_ch,
   crtm_rsp_if  rsp_ch,
   crtm_csr_if  csr_ch,
   output int   mismatch_count,
   output int   readings_pending
);

   // One result transaction as the block should present it.
   typedef struct packed {
      logic [CODE_W-1:0] sample_ohms;
      logic              range_flag;
      logic              group_done;
      logic [CODE_W-1:0] trimmed_ohms;
   } reading_t;

   // Calibration copy and group statistics of the predictor.
   logic [CODE_W-1:0] cal_low;
   logic [CODE_W-1:0] cal_high;
   logic [3:0]        group_count;
   logic [SUM_W-1:0]  group_sum;
   logic [CODE_W-1:0] group_min;
   logic [CODE_W-1:0] group_max;

   reading_t expected_readings[$];
   int       failures = 0;

   // Clear the statistics of the group that is being collected.
   function automatic void restart_group();
      group_count = '0;
      group_sum   = '0;
      group_min   = CODE_W'(OHM_MAX);
      group_max   = '0;
   endfunction

   // Calibrate one code, fold it into the group and close the group when it is full.
   function automatic reading_t predict_reading(input logic [CODE_W-1:0] code);
      longint      span;
      longint      scaled;
      longint      ohms;
      int unsigned ends;
      int unsigned rest;
      reading_t    r;
      r = '0;
      span = longint'(cal_high) - longint'(cal_low);
      if (span == 0) begin
         r.sample_ohms = CODE_W'(OHM_MAX);
         r.range_flag  = 1'b1;
      end else begin
         // Signed division truncates toward zero, as the calibration requires.
         scaled = (longint'(code) - longint'(cal_low)) * OHM_SPAN;
         ohms   = scaled / span + OHM_BASE;
         if (ohms < 0) begin
            r.sample_ohms = '0;
            r.range_flag  = 1'b1;
         end else if (ohms > OHM_MAX) begin
            r.sample_ohms = CODE_W'(OHM_MAX);
            r.range_flag  = 1'b1;
         end else begin
            r.sample_ohms = CODE_W'(ohms);
         end
      end

      // The clamped value is what enters the statistics.
      group_sum = group_sum + SUM_W'(r.sample_ohms);
      if (r.sample_ohms < group_min) group_min = r.sample_ohms;
      if (r.sample_ohms > group_max) group_max = r.sample_ohms;

      if (32'(group_count) + 1 >= GROUP_SIZE) begin
         ends = 32'(group_min) + 32'(group_max);
         rest = (32'(group_sum) >= ends) ? 32'(group_sum) - ends : 0;
         rest = rest / TRIM_DIV;
         r.trimmed_ohms = (rest > OHM_MAX) ? CODE_W'(OHM_MAX) : CODE_W'(rest);
         r.group_done   = 1'b1;
         restart_group();
      end else begin
         group_count = group_count + 4'd1;
      end
      return r;
   endfunction

   // Compare one result transaction with the oldest expected reading.
   function automatic void check_reading();
      reading_t want;
      if (expected_readings.size() == 0) begin
         $error("result transaction with no reading expected: sample_ohms %0d",
                rsp_ch.sample_ohms);
         failures++;
         return;
      end
      want = expected_readings.pop_front();
      if (rsp_ch.sample_ohms !== want.sample_ohms) begin
         $error("sample_ohms: expected %0d, actual %0d", want.sample_ohms, rsp_ch.sample_ohms);
         failures++;
      end
      if (rsp_ch.range_flag !== want.range_flag) begin
         $error("range_flag: expected %0d, actual %0d", want.range_flag, rsp_ch.range_flag);
         failures++;
      end
      if (rsp_ch.group_done !== want.group_done) begin
         $error("group_done: expected %0d, actual %0d", want.group_done, rsp_ch.group_done);
         failures++;
      end
      if (rsp_ch.trimmed_ohms !== want.trimmed_ohms) begin
         $error("trimmed_ohms: expected %0d, actual %0d",
                want.trimmed_ohms, rsp_ch.trimmed_ohms);
         failures++;
      end
   endfunction

   // Watch all three channels at each rising edge.
   always @(posedge clock) begin
      if (reset) begin
         cal_low  = '0;
         cal_high = CODE_W'(OHM_MAX);
         restart_group();
         expected_readings.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_reading();
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.reg_index)
               REG_LOW_REF:  cal_low = csr_ch.wr_data;
               REG_HIGH_REF: cal_high = csr_ch.wr_data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            expected_readings.push_back(predict_reading(req_ch.adc_code));
      end
      mismatch_count   <= failures;
      readings_pending <= expected_readings.size();
   end

endmodule

// ===== test/calibrated_resistance_trimmed_mean_test.sv =====
// Top of the calibrated resistance testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module calibrated_resistance_trimmed_mean_test;
   import crtm_pkg::*;

   localparam int PHASE_COUNT   = 10;
   localparam int PHASE_SAMPLES = 185;
   localparam int SETTLE_CYCLES = 80;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_UNUSED = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_LAST_UNUSED  = '1;

   // Calibration settings used by the random phases.
   typedef enum int {
      CAL_WINDOW,
      CAL_INVERTED,
      CAL_RANDOM,
      CAL_FLAT,
      CAL_NARROW,
      CAL_FULL_SCALE,
      CAL_REVERSED_FULL
   } cal_kind_t;

   localparam cal_kind_t PHASE_PLAN[PHASE_COUNT] = '{
      CAL_WINDOW, CAL_INVERTED, CAL_RANDOM, CAL_FLAT, CAL_NARROW,
      CAL_FULL_SCALE, CAL_REVERSED_FULL, CAL_WINDOW, CAL_RANDOM, CAL_NARROW
   };

   logic clock;
   logic reset;
   int   send_gap_pct = 0;
   int   stall_pct = 0;
   int   mismatch_count;
   int   readings_pending;

   // Calibration currently programmed, used to aim the random codes.
   logic [CODE_W-1:0] cur_low;
   logic [CODE_W-1:0] cur_high;

   crtm_req_if req_ch();
   crtm_rsp_if rsp_ch();
   crtm_csr_if csr_ch();

   calibrated_resistance_trimmed_mean dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   calibrated_resistance_trimmed_mean_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_ch           (csr_ch),
      .mismatch_count   (mismatch_count),
      .readings_pending (readings_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Receiver: stalls at random according to the phase.
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Offer one code and hold it until the block takes the transaction.
   task automatic send_code(input logic [CODE_W-1:0] code);
      int gap;
      gap = 0;
      if (send_gap_pct > 0) begin
         if ($urandom_range(99) < 8) gap = $urandom_range(80, 20);
         while ($urandom_range(99) < send_gap_pct) gap++;
      end
      repeat (gap) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.adc_code <= code;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stop sending and wait until every expected reading has come back.
   task automatic wait_until_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (readings_pending != 0);
   endtask

   // One register write transaction.
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CODE_W-1:0] value);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= index;
      csr_ch.wr_data   <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Program both calibration codes while the block is idle, in random order.
   task automatic set_calibration(input logic [CODE_W-1:0] low_code,
                                  input logic [CODE_W-1:0] high_code);
      wait_until_drained();
      if ($urandom_range(99) < 30)
         write_register(CSR_IDX_W'($urandom_range(255, 2)), CODE_W'($urandom));
      if ($urandom_range(1) == 0) begin
         write_register(REG_LOW_REF, low_code);
         write_register(REG_HIGH_REF, high_code);
      end else begin
         write_register(REG_HIGH_REF, high_code);
         write_register(REG_LOW_REF, low_code);
      end
      cur_low  = low_code;
      cur_high = high_code;
   endtask

   // Most codes fall near the calibration window; the rest are edges or anything.
   function automatic logic [CODE_W-1:0] pick_code();
      int lo_end;
      int hi_end;
      int choice;
      lo_end = (cur_low < cur_high) ? int'(cur_low) : int'(cur_high);
      hi_end = (cur_low < cur_high) ? int'(cur_high) : int'(cur_low);
      choice = $urandom_range(99);
      if (choice < 55) begin
         lo_end = (lo_end > 64) ? lo_end - 64 : 0;
         hi_end = (hi_end < OHM_MAX - 64) ? hi_end + 64 : OHM_MAX;
         return CODE_W'($urandom_range(hi_end, lo_end));
      end
      if (choice < 70) begin
         case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return cur_low;
            default: return cur_high;
         endcase
      end
      return CODE_W'($urandom);
   endfunction

   // Choose the calibration codes of one random phase.
   task automatic apply_phase_setting(input cal_kind_t kind);
      int lo;
      int hi;
      case (kind)
         CAL_WINDOW: begin
            lo = $urandom_range(40000, 0);
            hi = lo + $urandom_range(25000, 200);
         end
         CAL_INVERTED: begin
            hi = $urandom_range(30000, 0);
            lo = hi + $urandom_range(35000, 200);
         end
         CAL_FLAT: begin
            lo = $urandom_range(OHM_MAX, 0);
            hi = lo;
         end
         CAL_NARROW: begin
            lo = $urandom_range(60000, 0);
            hi = lo + $urandom_range(16, 1);
         end
         CAL_FULL_SCALE: begin
            lo = 0;
            hi = OHM_MAX;
         end
         CAL_REVERSED_FULL: begin
            lo = OHM_MAX;
            hi = 0;
         end
         default: begin
            lo = $urandom_range(OHM_MAX, 0);
            hi = $urandom_range(OHM_MAX, 0);
         end
      endcase
      set_calibration(CODE_W'(lo), CODE_W'(hi));
   endtask

   // Stimulus and verdict.
   initial begin
      int phase;
      int n;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.adc_code  = '0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.reg_index = '0;
      csr_ch.wr_data   = '0;
      cur_low          = '0;
      cur_high         = CODE_W'(OHM_MAX);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Calibration out of reset: full code range onto 100..1000 ohms.
      send_code('0);
      send_code('1);
      send_code(16'h8000);
      send_code(16'h5555);
      send_code(16'hAAAA);

      // A realistic window, with codes below and far above it.
      set_calibration(16'd1000, 16'd2000);
      send_code(16'd1000);
      send_code(16'd2000);
      send_code('0);
      send_code('1);
      send_code(16'd1500);

      // A span of one code drives the far codes above the clamp.
      set_calibration(16'd1000, 16'd1001);
      send_code('1);
      send_code(16'd1000);

      // Equal calibration codes.
      set_calibration(16'h1234, 16'h1234);
      send_code(16'h1234);
      send_code('0);

      // Inverted calibration with a negative span.
      set_calibration(16'd60000, 16'd100);
      send_code(16'd100);
      send_code(16'd60000);
      send_code('1);
      send_code('0);

      // Writes to unused indexes must leave the calibration alone.
      wait_until_drained();
      write_register(REG_FIRST_UNUSED, '1);
      write_register(REG_LAST_UNUSED, '0);
      set_calibration('1, '0);
      send_code('0);
      send_code('1);

      // Both codes at zero.
      set_calibration('0, '0);
      send_code('1);

      // Random phases, each with its own calibration and idling pattern.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         apply_phase_setting(PHASE_PLAN[phase]);
         case (phase % 4)
            0: begin
               send_gap_pct <= 0;
               stall_pct    <= 0;
            end
            1: begin
               send_gap_pct <= 62;
               stall_pct    <= 0;
            end
            2: begin
               send_gap_pct <= 0;
               stall_pct    <= 62;
            end
            default: begin
               send_gap_pct <= 28;
               stall_pct    <= 28;
            end
         endcase
         for (n = 0; n < PHASE_SAMPLES; n++) begin
            // Once, let the block empty out completely in the middle of a phase.
            if (phase == 2 && n == PHASE_SAMPLES / 2) wait_until_drained();
            send_code(pick_code());
         end
      end

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && readings_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
